// ===== src/ook_pulse_pair_code_decoder_top_assert.svh =====
// Assertion macros for the pulse-pair code decoder.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef OOK_PULSE_PAIR_CODE_DECODER_TOP_ASSERT_SVH
`define OOK_PULSE_PAIR_CODE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define OOKPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OOKPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ookpd_pkg.sv =====
// Shared widths, register codes, reset values and the threshold struct
// for the pulse-pair code decoder. No dependencies.
package ookpd_pkg;

    localparam int MAX_CODE_BITS  = 32;
    localparam int DURATION_WIDTH = 24;

    localparam int CODE_W     = 32;
    localparam int BITS_W     = 6;
    localparam int BITS_W1    = BITS_W + 1;
    localparam int NOM_W      = 16;
    localparam int TOL_W      = 7;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // floor(p / 100) as (p * RECIP_100) >> RECIP_SHIFT, exact for p < 2**PROD_W
    localparam int PROD_W      = NOM_W + TOL_W;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam logic [RECIP_W-1:0] RECIP_100 =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
    localparam int SCALED_W = PROD_W + RECIP_W;
    localparam int DEV_W    = SCALED_W - RECIP_SHIFT;
    localparam int BND_W    = DEV_W + 1;

    localparam logic [BITS_W1-1:0] MAX_BITS_V = BITS_W1'(MAX_CODE_BITS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_US      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_US       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_PCT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP_BITS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES   = 3'd5;

    localparam logic [NOM_W-1:0]  RST_SHORT_US      = 16'd500;
    localparam logic [NOM_W-1:0]  RST_LONG_US       = 16'd1500;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE_PCT = 7'd40;
    localparam logic [BITS_W-1:0] RST_CODE_BITS     = 6'd10;
    localparam logic [BITS_W-1:0] RST_MIN_KEEP_BITS = 6'd8;
    localparam logic [CNT_W-1:0]  RST_MIN_SAMPLES   = 8'd10;

    typedef struct packed {
        logic signed [BND_W-1:0] short_lo;
        logic [BND_W-1:0]        short_hi;
        logic signed [BND_W-1:0] long_lo;
        logic [BND_W-1:0]        long_hi;
        logic [BITS_W-1:0]       code_bits;
        logic [BITS_W-1:0]       min_keep_bits;
        logic [CNT_W-1:0]        min_samples;
    } t_cfg;

endpackage

// ===== src/ookpd_in_if.sv =====
// Sample channel: valid/ready beat carrying one signed duration and framing.
// Depends on nothing; width set by DW.
interface ookpd_in_if #(parameter int DW = 24) ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] duration;
    logic                 first;
    logic                 last;

    modport source (output valid, output duration, output first, output last, input ready);
    modport sink   (input valid, input duration, input first, input last, output ready);
endinterface

// ===== src/ookpd_out_if.sv =====
// Verdict channel: valid/ready beat carrying ok, code and bit count.
// Depends on ookpd_pkg for the field widths.
interface ookpd_out_if import ookpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [CODE_W-1:0] code;
    logic [BITS_W-1:0] bits;

    modport source (output valid, output ok, output code, output bits, input ready);
    modport sink   (input valid, input ok, input code, input bits, output ready);
endinterface

// ===== src/ookpd_bounds.sv =====
// Configuration registers and the match windows derived from them.
// Depends on ookpd_pkg (t_cfg, register codes, reciprocal constant).
module ookpd_bounds import ookpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [NOM_W-1:0]  r_short_us, n_short_us;
    logic [NOM_W-1:0]  r_long_us, n_long_us;
    logic [TOL_W-1:0]  r_tol, n_tol;
    logic [BITS_W-1:0] r_code_bits, n_code_bits;
    logic [BITS_W-1:0] r_min_keep, n_min_keep;
    logic [CNT_W-1:0]  r_min_samples, n_min_samples;

    logic [PROD_W-1:0] r_prod_short, r_prod_long;

    logic signed [BND_W-1:0] r_short_lo, r_long_lo;
    logic [BND_W-1:0]        r_short_hi, r_long_hi;

    logic [SCALED_W-1:0] w_scaled_short, w_scaled_long;
    logic [DEV_W-1:0]    w_dev_short, w_dev_long;

    always_comb begin
        n_short_us    = r_short_us;
        n_long_us     = r_long_us;
        n_tol         = r_tol;
        n_code_bits   = r_code_bits;
        n_min_keep    = r_min_keep;
        n_min_samples = r_min_samples;
        if (!i_rst_n) begin
            n_short_us    = RST_SHORT_US;
            n_long_us     = RST_LONG_US;
            n_tol         = RST_TOLERANCE_PCT;
            n_code_bits   = RST_CODE_BITS;
            n_min_keep    = RST_MIN_KEEP_BITS;
            n_min_samples = RST_MIN_SAMPLES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SHORT_US:      n_short_us    = i_cfg_data[NOM_W-1:0];
                CFG_LONG_US:       n_long_us     = i_cfg_data[NOM_W-1:0];
                CFG_TOLERANCE_PCT: n_tol         = i_cfg_data[TOL_W-1:0];
                CFG_CODE_BITS:     n_code_bits   = i_cfg_data[BITS_W-1:0];
                CFG_MIN_KEEP_BITS: n_min_keep    = i_cfg_data[BITS_W-1:0];
                CFG_MIN_SAMPLES:   n_min_samples = i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // deviation = floor(nominal * tolerance / 100) via reciprocal multiply
    assign w_scaled_short = {{RECIP_W{1'b0}}, r_prod_short} * {{PROD_W{1'b0}}, RECIP_100};
    assign w_scaled_long  = {{RECIP_W{1'b0}}, r_prod_long} * {{PROD_W{1'b0}}, RECIP_100};
    assign w_dev_short    = w_scaled_short[RECIP_SHIFT +: DEV_W];
    assign w_dev_long     = w_scaled_long[RECIP_SHIFT +: DEV_W];

    // products follow next config values so windows settle at the edge after the write edge
    always_ff @(posedge i_clk) begin
        r_short_us    <= n_short_us;
        r_long_us     <= n_long_us;
        r_tol         <= n_tol;
        r_code_bits   <= n_code_bits;
        r_min_keep    <= n_min_keep;
        r_min_samples <= n_min_samples;
        r_prod_short  <= {{TOL_W{1'b0}}, n_short_us} * {{NOM_W{1'b0}}, n_tol};
        r_prod_long   <= {{TOL_W{1'b0}}, n_long_us} * {{NOM_W{1'b0}}, n_tol};
        r_short_lo    <= $signed({{(BND_W-NOM_W){1'b0}}, r_short_us}
                                 - {{(BND_W-DEV_W){1'b0}}, w_dev_short});
        r_short_hi    <= {{(BND_W-NOM_W){1'b0}}, r_short_us}
                         + {{(BND_W-DEV_W){1'b0}}, w_dev_short};
        r_long_lo     <= $signed({{(BND_W-NOM_W){1'b0}}, r_long_us}
                                 - {{(BND_W-DEV_W){1'b0}}, w_dev_long});
        r_long_hi     <= {{(BND_W-NOM_W){1'b0}}, r_long_us}
                         + {{(BND_W-DEV_W){1'b0}}, w_dev_long};
    end

    assign o_cfg.short_lo      = r_short_lo;
    assign o_cfg.short_hi      = r_short_hi;
    assign o_cfg.long_lo       = r_long_lo;
    assign o_cfg.long_hi       = r_long_hi;
    assign o_cfg.code_bits     = r_code_bits;
    assign o_cfg.min_keep_bits = r_min_keep;
    assign o_cfg.min_samples   = r_min_samples;

endmodule

// ===== src/ookpd_decode.sv =====
// Sample register, pair decoder state and verdict register.
// Depends on ookpd_pkg, ookpd_in_if, ookpd_out_if and the assertion macros.
`include "ook_pulse_pair_code_decoder_top_assert.svh"

module ookpd_decode import ookpd_pkg::*; #(
    parameter int DW = DURATION_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    ookpd_in_if.sink    i_in,
    ookpd_out_if.source o_out
);

    localparam int CMP_W = (DW > BND_W) ? DW : BND_W;

    // sample register
    logic          r_in_valid;
    logic [DW-1:0] r_in_dur;
    logic          r_in_first;
    logic          r_in_last;

    // capture state
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_expect_gap, n_expect_gap;
    logic              r_held_neg, n_held_neg;
    logic              r_held_short, n_held_short;
    logic              r_held_long, n_held_long;
    logic [CODE_W-1:0] r_shift, n_shift;
    logic [BITS_W-1:0] r_bits_found, n_bits_found;
    logic              r_decided, n_decided;
    logic              r_success, n_success;

    // verdict register
    logic              r_out_valid;
    logic              r_out_ok;
    logic [CODE_W-1:0] r_out_code;
    logic [BITS_W-1:0] r_out_bits;

    logic              w_go;
    logic              w_neg;
    logic [DW-1:0]     w_mag;
    logic              w_m_short;
    logic              w_m_long;
    logic              w_bit_zero;
    logic              w_pair_ok;
    logic              w_cb_ok;
    logic              w_is_first;
    logic              w_ok;
    logic [CODE_W-1:0] w_code;

    function automatic logic f_near(input logic [DW-1:0] mag,
                                    input logic signed [BND_W-1:0] lo,
                                    input logic [BND_W-1:0] hi);
        logic [CMP_W-1:0] mag_x;
        mag_x = CMP_W'(mag);
        return (lo[BND_W-1] || mag_x >= CMP_W'($unsigned(lo))) && mag_x <= CMP_W'(hi);
    endfunction

    // stall only when a verdict must load into a full output register
    assign w_go       = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_dur   <= i_in.duration;
            r_in_first <= i_in.first;
            r_in_last  <= i_in.last;
        end
    end

    assign w_neg      = r_in_dur[DW-1];
    assign w_mag      = w_neg ? (~r_in_dur + 1'b1) : r_in_dur;
    assign w_m_short  = f_near(w_mag, i_cfg.short_lo, i_cfg.short_hi);
    assign w_m_long   = f_near(w_mag, i_cfg.long_lo, i_cfg.long_hi);
    assign w_bit_zero = r_held_short && w_m_long;
    assign w_pair_ok  = w_bit_zero || (r_held_long && w_m_short);
    assign w_cb_ok    = (i_cfg.code_bits != '0) && ({1'b0, i_cfg.code_bits} <= MAX_BITS_V);

    always_comb begin
        n_count      = r_count;
        n_expect_gap = r_expect_gap;
        n_held_neg   = r_held_neg;
        n_held_short = r_held_short;
        n_held_long  = r_held_long;
        n_shift      = r_shift;
        n_bits_found = r_bits_found;
        n_decided    = r_decided;
        n_success    = r_success;
        if (r_in_first) begin
            n_count      = '0;
            n_expect_gap = 1'b0;
            n_shift      = '0;
            n_bits_found = '0;
            n_decided    = 1'b0;
            n_success    = 1'b0;
        end
        w_is_first = (n_count == '0);
        if (n_count != '1) begin
            n_count = n_count + 1'b1;
        end
        // skip a leading low sample, ignore everything after a decision
        if (!n_decided && !(w_is_first && w_neg)) begin
            if (!n_expect_gap) begin
                n_expect_gap = 1'b1;
                n_held_neg   = w_neg;
                n_held_short = w_m_short;
                n_held_long  = w_m_long;
            end else begin
                n_expect_gap = 1'b0;
                priority if (r_held_neg) begin
                    n_decided = 1'b1;
                    n_success = 1'b0;
                end else if (!w_pair_ok) begin
                    if (n_bits_found >= i_cfg.min_keep_bits) begin
                        n_decided = 1'b1;
                        n_success = 1'b0;
                    end else begin
                        n_shift      = '0;
                        n_bits_found = '0;
                    end
                end else begin
                    n_shift = {n_shift[CODE_W-2:0], !w_bit_zero};
                    if (n_bits_found != '1) begin
                        n_bits_found = n_bits_found + 1'b1;
                    end
                    if (w_cb_ok && n_bits_found == i_cfg.code_bits) begin
                        n_decided = 1'b1;
                        n_success = 1'b1;
                    end
                end
            end
        end
        w_ok   = n_success && (n_count >= i_cfg.min_samples);
        w_code = n_shift;
        // verdict taken: start a fresh capture
        if (r_in_last) begin
            n_count      = '0;
            n_expect_gap = 1'b0;
            n_shift      = '0;
            n_bits_found = '0;
            n_decided    = 1'b0;
            n_success    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_expect_gap <= 1'b0;
            r_shift      <= '0;
            r_bits_found <= '0;
            r_decided    <= 1'b0;
            r_success    <= 1'b0;
        end else if (w_go) begin
            r_count      <= n_count;
            r_expect_gap <= n_expect_gap;
            r_shift      <= n_shift;
            r_bits_found <= n_bits_found;
            r_decided    <= n_decided;
            r_success    <= n_success;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_held_neg   <= n_held_neg;
            r_held_short <= n_held_short;
            r_held_long  <= n_held_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in_last) begin
            r_out_ok   <= w_ok;
            r_out_code <= w_ok ? w_code : '0;
            r_out_bits <= w_ok ? i_cfg.code_bits : '0;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.ok    = r_out_ok;
    assign o_out.code  = r_out_code;
    assign o_out.bits  = r_out_bits;

    `OOKPD_ASSERT_NOW(a_ok_bits, r_out_valid && r_out_ok,
        r_out_bits == i_cfg.code_bits && r_out_bits != '0, "ok verdict with wrong bit count")
    `OOKPD_ASSERT_NOW(a_fail_zero, r_out_valid && !r_out_ok,
        r_out_code == '0 && r_out_bits == '0, "failed verdict carries a code")
    `OOKPD_ASSERT_NOW(a_load_on_last, $rose(r_out_valid),
        $past(r_in_valid && r_in_last), "verdict without a last sample")
    `OOKPD_ASSERT_NOW(a_success_decided, r_success, r_decided, "success without decision")

endmodule

// ===== src/ook_pulse_pair_code_decoder_top.sv =====
// A capture's last sample passes the input register, then its verdict loads into the
// verdict register once that register is free.
// Throughput: one sample per cycle; input stalls only while a verdict waits in a
// full output register. The capture state loop (compares, pair check, shift) is combinational.
// A config write passes the config and product registers, then the window registers.
// Reset (i_rst_n low, synchronous) restores register defaults and clears capture state but the held pulse flags.
module ook_pulse_pair_code_decoder_top import ookpd_pkg::*; #(
    parameter int DURATION_W = DURATION_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ookpd_in_if.sink              i_in,
    ookpd_out_if.source           o_out
);

    t_cfg w_cfg;

    ookpd_bounds u_bounds (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ookpd_decode #(.DW(DURATION_W)) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench for ook_pulse_pair_code_decoder_top: a directed capture table, then
// random captures under several register settings, scored against a decoder model.
// Depends on ookpd_pkg, ookpd_in_if, ookpd_out_if and the top level from src.
module tb;
    import ookpd_pkg::*;

    localparam int LONG_STALL   = 300;
    localparam int QUIET_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 20;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] bits;
    } t_verdict;

    typedef struct packed {
        logic signed [DURATION_WIDTH-1:0] dur;
        logic                             first;
        logic                             last;
        logic                             fixed;
        t_verdict                         fixed_v;
    } t_sample;

    localparam t_verdict NO_V = '0;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ookpd_in_if #(.DW(DURATION_WIDTH)) in_if ();
    ookpd_out_if out_if ();

    ook_pulse_pair_code_decoder_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // register mirror
    logic [NOM_W-1:0]  cfg_short;
    logic [NOM_W-1:0]  cfg_long;
    logic [TOL_W-1:0]  cfg_tol;
    logic [BITS_W-1:0] cfg_code_bits;
    logic [BITS_W-1:0] cfg_keep_bits;
    logic [CNT_W-1:0]  cfg_min_samples;

    // decoder model state
    int                cap_count;
    bit                want_gap;
    longint            pulse_held;
    logic [CODE_W-1:0] code_acc;
    int                bits_seen;
    bit                settled;
    bit                decoded;

    t_sample  sample_q[$];
    t_verdict verdict_q[$];
    int       errors;
    int       items_queued;
    bit       beat_taken;
    bit       took_beat;
    int       burst_left;
    int       gap_left;
    bit       stall_req;
    int       stall_left;
    logic [31:0] rx_tick;

    // pulse, gap, ..., with the verdict typed in where it is plain
    t_sample dir_rows [29] = '{
        '{-24'sd9000,    1'b1, 1'b0, 1'b0, NO_V},   // leading low level, skipped
        '{24'sd1500,     1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd500,     1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd500,      1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd1500,    1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd2100,     1'b0, 1'b0, 1'b0, NO_V},   // window edges, inclusive
        '{-24'sd300,     1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd8388607,  1'b0, 1'b1, 1'b1, '{1'b1, 32'd5, 6'd3}},
        '{24'h800000,    1'b1, 1'b0, 1'b0, NO_V},
        '{-24'sd500,     1'b0, 1'b0, 1'b0, NO_V},   // low level where a pulse belongs
        '{-24'sd1500,    1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd700,      1'b0, 1'b1, 1'b1, NO_V},
        '{24'sd1500,     1'b1, 1'b0, 1'b0, NO_V},
        '{-24'sd500,     1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd1500,     1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd500,     1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd2101,     1'b0, 1'b0, 1'b0, NO_V},   // bad pair with the keep count reached
        '{-24'sd500,     1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd500,      1'b0, 1'b1, 1'b1, NO_V},
        '{24'sd299,      1'b0, 1'b0, 1'b0, NO_V},   // no first flag; bad pair restarts
        '{-24'sd1500,    1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd900,      1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd700,     1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd500,      1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd1500,    1'b0, 1'b0, 1'b0, NO_V},
        '{24'sd500,      1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd1500,    1'b0, 1'b0, 1'b0, NO_V},
        '{-24'sd3,       1'b0, 1'b1, 1'b0, NO_V},   // after the decision
        '{24'sd1000,     1'b1, 1'b1, 1'b1, NO_V}    // too few samples, unpaired pulse
    };

    int phase_regs [5][6] = '{
        '{500,   1500,  40,  10, 8,  10},
        '{1,     65535, 0,   1,  0,  0},
        '{65535, 3,     100, 32, 32, 255},
        '{300,   900,   127, 0,  63, 4},
        '{700,   2100,  25,  40, 5,  20}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void clear_capture();
        cap_count  = 0;
        want_gap   = 1'b0;
        pulse_held = 0;
        code_acc   = '0;
        bits_seen  = 0;
        settled    = 1'b0;
        decoded    = 1'b0;
    endfunction

    function automatic bit in_window(longint d, longint nom);
        longint mag;
        longint tol;
        longint dev;
        tol = cfg_tol;
        mag = (d < 0) ? -d : d;
        dev = (nom * tol) / 100;
        return (mag >= nom - dev) && (mag <= nom + dev);
    endfunction

    function automatic void decode_sample(input logic signed [DURATION_WIDTH-1:0] d_in,
                                          input logic first_in, input logic last_in,
                                          output bit has_v, output t_verdict v);
        longint dur;
        bit     lead;
        int     b;
        dur = d_in;
        v = NO_V;
        if (first_in)
            clear_capture();
        lead = (cap_count == 0);
        if (cap_count < 255)
            cap_count++;
        if (!settled && !(lead && dur < 0)) begin
            if (!want_gap) begin
                pulse_held = dur;
                want_gap = 1'b1;
            end else begin
                want_gap = 1'b0;
                if (pulse_held < 0) begin
                    settled = 1'b1;
                    decoded = 1'b0;
                end else begin
                    b = -1;
                    if (in_window(pulse_held, cfg_short) && in_window(dur, cfg_long))
                        b = 0;
                    else if (in_window(pulse_held, cfg_long) && in_window(dur, cfg_short))
                        b = 1;
                    if (b < 0) begin
                        if (bits_seen >= cfg_keep_bits) begin
                            settled = 1'b1;
                            decoded = 1'b0;
                        end else begin
                            code_acc = '0;
                            bits_seen = 0;
                        end
                    end else begin
                        code_acc = {code_acc[CODE_W-2:0], b[0]};
                        if (bits_seen < 63)
                            bits_seen++;
                        if (cfg_code_bits >= 1 && cfg_code_bits <= MAX_CODE_BITS &&
                            bits_seen == cfg_code_bits) begin
                            settled = 1'b1;
                            decoded = 1'b1;
                        end
                    end
                end
            end
        end
        has_v = last_in;
        if (last_in) begin
            v.ok   = decoded && cap_count >= cfg_min_samples;
            v.code = v.ok ? code_acc : '0;
            v.bits = v.ok ? cfg_code_bits : '0;
            clear_capture();
        end
    endfunction

    task automatic check_field(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
        end
    endtask

    // model the block on every accepted beat, score every verdict beat
    always @(posedge i_clk) begin : scoreboard
        bit       got_v;
        t_verdict pv;
        t_verdict ev;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                decode_sample(in_if.duration, in_if.first, in_if.last, got_v, pv);
                if (got_v)
                    verdict_q.push_back(sample_q[0].fixed ? sample_q[0].fixed_v : pv);
                beat_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected verdict, got ok=%0d code=%0d bits=%0d",
                             $time, out_if.ok, out_if.code, out_if.bits);
                end else begin
                    ev = verdict_q.pop_front();
                    check_field("ok", ev.ok, out_if.ok);
                    check_field("code", ev.code, out_if.code);
                    check_field("bits", ev.bits, out_if.bits);
                end
            end
        end
    end

    // sender: bursts of beats with random gaps, holding a beat until it is taken
    always @(negedge i_clk) begin
        took_beat = beat_taken;
        if (beat_taken) begin
            sample_q.delete(0);
            beat_taken = 1'b0;
        end
        if (!(in_if.valid && !took_beat)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                in_if.valid    <= 1'b1;
                in_if.duration <= sample_q[0].dur;
                in_if.first    <= sample_q[0].first;
                in_if.last     <= sample_q[0].last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6)
                                                      : $urandom_range(10, 60);
                    gap_left = $urandom_range(0, 3) ? $urandom_range(1, 5) : 0;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver: cycling stall patterns, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (stall_req) begin
            stall_left = LONG_STALL;
            stall_req = 1'b0;
        end
        rx_tick++;
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            case (rx_tick[7:6])
                2'd0:    out_if.ready <= 1'b1;
                2'd1:    out_if.ready <= ($urandom_range(0, 3) != 0);
                2'd2:    out_if.ready <= ((rx_tick % 5) < 2);
                default: out_if.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    function automatic int near_mag(int nom);
        int dev;
        int lo;
        int hi;
        dev = nom * int'(cfg_tol) / 100;
        lo = (nom > dev) ? nom - dev : 0;
        hi = nom + dev;
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            2:       return hi + 1;
            3:       return (lo > 0) ? lo - 1 : hi + 1;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // one capture of mostly well-formed pulse/gap pairs, closed by a last beat
    task automatic gen_capture();
        t_sample cap[$];
        t_sample s;
        int      target;
        int      k;
        int      pick;
        bit      b;
        s = '0;
        if ($urandom_range(0, 1)) begin
            s.dur = DURATION_WIDTH'(-int'($urandom_range(1, 20000)));
            cap.push_back(s);
        end
        target = (cfg_code_bits >= 1 && cfg_code_bits <= MAX_CODE_BITS) ?
                 int'(cfg_code_bits) : $urandom_range(1, 12);
        if ($urandom_range(0, 5) == 0)
            target = $urandom_range(0, target);
        for (k = 0; k < target; k++) begin
            pick = $urandom_range(0, 19);
            b = $urandom_range(0, 1);
            s.dur = DURATION_WIDTH'(near_mag(b ? cfg_long : cfg_short));
            if (pick == 0)
                s.dur = DURATION_WIDTH'($urandom_range(0, 200000));
            else if (pick == 1)
                s.dur = -s.dur;
            cap.push_back(s);
            s.dur = DURATION_WIDTH'(near_mag(b ? cfg_short : cfg_long));
            if (pick == 0)
                s.dur = DURATION_WIDTH'($urandom);
            if ($urandom_range(0, 7) != 0)
                s.dur = -s.dur;
            cap.push_back(s);
        end
        repeat ($urandom_range(0, 2)) begin
            s.dur = DURATION_WIDTH'($urandom);
            cap.push_back(s);
        end
        // pad up to the sample floor now and then so long floors can still pass
        if ($urandom_range(0, 3) == 0) begin
            while (cap.size() < cfg_min_samples) begin
                s.dur = DURATION_WIDTH'($urandom);
                cap.push_back(s);
            end
        end
        if (cap.size() == 0) begin
            s.dur = DURATION_WIDTH'($urandom);
            cap.push_back(s);
        end
        cap[0].first = ($urandom_range(0, 7) != 0);
        cap[cap.size() - 1].last = 1'b1;
        foreach (cap[k])
            sample_q.push_back(cap[k]);
        items_queued += cap.size();
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (sample_q.size() != 0 || verdict_q.size() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(v);
        case (idx)
            CFG_SHORT_US:      cfg_short       = NOM_W'(v);
            CFG_LONG_US:       cfg_long        = NOM_W'(v);
            CFG_TOLERANCE_PCT: cfg_tol         = TOL_W'(v);
            CFG_CODE_BITS:     cfg_code_bits   = BITS_W'(v);
            CFG_MIN_KEEP_BITS: cfg_keep_bits   = BITS_W'(v);
            CFG_MIN_SAMPLES:   cfg_min_samples = CNT_W'(v);
            default: ;
        endcase
    endtask

    task automatic set_registers(input int s, input int l, input int t,
                                 input int c, input int k, input int m);
        drain();
        write_reg(CFG_SHORT_US, s);
        write_reg(CFG_LONG_US, l);
        write_reg(CFG_TOLERANCE_PCT, t);
        write_reg(CFG_CODE_BITS, c);
        write_reg(CFG_MIN_KEEP_BITS, k);
        write_reg(CFG_MIN_SAMPLES, m);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        // let the match windows pick up the new values
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    initial begin : main
        int ph;
        int start;
        int k;
        int n;
        errors         = 0;
        items_queued   = 0;
        beat_taken     = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        stall_req      = 1'b0;
        stall_left     = 0;
        rx_tick        = '0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.duration = '0;
        in_if.first    = 1'b0;
        in_if.last     = 1'b0;
        out_if.ready   = 1'b0;
        cfg_short       = RST_SHORT_US;
        cfg_long        = RST_LONG_US;
        cfg_tol         = RST_TOLERANCE_PCT;
        cfg_code_bits   = RST_CODE_BITS;
        cfg_keep_bits   = RST_MIN_KEEP_BITS;
        cfg_min_samples = RST_MIN_SAMPLES;
        clear_capture();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_registers(RST_SHORT_US, RST_LONG_US, RST_TOLERANCE_PCT, 3, 2, 4);
        foreach (dir_rows[k])
            sample_q.push_back(dir_rows[k]);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph < 5)
                set_registers(phase_regs[ph][0], phase_regs[ph][1], phase_regs[ph][2],
                              phase_regs[ph][3], phase_regs[ph][4], phase_regs[ph][5]);
            else
                set_registers($urandom_range(1, 3000), $urandom_range(1, 6000),
                              $urandom_range(0, 100), $urandom_range(1, 32),
                              $urandom_range(0, 32), $urandom_range(0, 40));
            if (ph == 0) begin
                // hold the output off while captures keep coming, then drain fully
                stall_req = 1'b1;
                repeat (4) gen_capture();
                drain();
            end
            start = items_queued;
            while (items_queued - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        sample_q.push_back('{DURATION_WIDTH'($urandom),
                                             ($urandom_range(0, 3) == 0),
                                             ($urandom_range(0, 3) == 0), 1'b0, NO_V});
                    items_queued += n;
                end else begin
                    gen_capture();
                end
            end
            gen_capture();
        end

        drain();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
